// File: design/flpw_pkg.sv
`timescale 1ns / 1ps
// Shared constants and helpers for the four-level page walker.
// No dependencies; imported by four_level_page_walker_unit.
package flpw_pkg;

    // Default table memory depth in 64-bit words (power of two)
    localparam int MEM_WORDS_DEF = 4096;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int VA_W    = 48;
    localparam int LEN_W   = 24;
    localparam int LDIX_W  = 12;
    localparam int WORD_W  = 64;
    localparam int PA_W    = 52;
    localparam int PAGE_W  = 50;   // range walk cursor, holds va + len + 4 KB
    localparam int VIDX_W  = 9;    // table index bits per level
    localparam int LVL_W   = 2;
    localparam int CFG_IX_W = 1;

    // Stream payload widths, padded to whole bytes
    localparam int IN_DATA_W  = 152;
    localparam int OUT_DATA_W = 56;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_LOAD      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TRANSLATE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MARK_EXEC = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IX_W-1:0] CFG_WINDOW_BASE = 1'b0;
    localparam logic [CFG_IX_W-1:0] CFG_ROOT_TABLE  = 1'b1;

    // Walk levels
    localparam logic [LVL_W-1:0] LVL_PML4 = 2'd0;
    localparam logic [LVL_W-1:0] LVL_PDPT = 2'd1;
    localparam logic [LVL_W-1:0] LVL_PD   = 2'd2;
    localparam logic [LVL_W-1:0] LVL_PT   = 2'd3;

    // Entry bits
    localparam int BIT_PRESENT = 0;
    localparam int BIT_LARGE   = 7;
    localparam logic [WORD_W-1:0] NOEXEC_CLEAR_MASK = 64'h7FFF_FFFF_FFFF_FFFF;

    // Range walk step of 16 KB and 4 KB rounding
    localparam logic [PAGE_W-1:0] PAGE_STEP  = 50'h4000;
    localparam logic [PAGE_W-1:0] PAGE_ROUND = 50'hFFF;

    // Pick the 9-bit table index of a virtual address for one level
    function automatic logic [VIDX_W-1:0] va_index(input logic [VA_W-1:0] va,
                                                  input logic [LVL_W-1:0] lvl);
        logic [VIDX_W-1:0] idx;
        begin
            unique case (lvl)
                LVL_PML4: idx = va[39 +: VIDX_W];
                LVL_PDPT: idx = va[30 +: VIDX_W];
                LVL_PD:   idx = va[21 +: VIDX_W];
                default:  idx = va[12 +: VIDX_W];
            endcase
            return idx;
        end
    endfunction

endpackage

// File: design/four_level_page_walker_unit.sv
`timescale 1ns / 1ps
// Four-level x86-64 style page table walker with an internal table memory.
// Depends on flpw_pkg for constants, command codes and the index helper.
//
// Page table words live in a single-port-write, single-port-read synchronous
// memory of MEM_WORDS 64-bit words (MEM_WORDS must be a power of two). One
// command is handled at a time; the input stream is ready only while the walker
// is idle, and the finished result sits in an output register so the next
// command can be taken while it waits. Each table memory read is registered,
// and each level needs one dependent read, from one to four levels per walk.
// A load writes its word and finishes, a translation reads from the top level
// down to a leaf or a fault, and a mark-executable range walks each 16 KB page
// in turn, writes back its leaf and stops at the first fault. Each table read
// address is window_base + table address + 8 * index, taken in words modulo
// MEM_WORDS. Table memory has no reset; only loaded words may be walked.
module four_level_page_walker_unit
#(
    parameter int MEM_WORDS = flpw_pkg::MEM_WORDS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,

    // Configuration write port
    input  logic                               cfg_we,
    input  logic [flpw_pkg::CFG_IX_W-1:0]      cfg_index,
    input  logic [flpw_pkg::PA_W-1:0]          cfg_wdata,

    // Command stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // cmd[1:0], virt_addr[49:2], range_length[73:50], entry_index[85:74],
    // entry_value[149:86], zero pad[151:150]
    input  logic [flpw_pkg::IN_DATA_W-1:0]     s_axis_tdata,

    // Result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // status[0], phys_addr[52:1], zero pad[55:53]
    output logic [flpw_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    import flpw_pkg::*;

    localparam int ADDR_W = $clog2(MEM_WORDS);
    localparam int SUM_W  = ADDR_W + 3;    // byte address bits that pick a word

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_CHECK,
        S_WRITE,
        S_DONE
    } state_t;

    // Unpacked command beat
    logic [CMD_W-1:0]  in_cmd;
    logic [VA_W-1:0]   in_va;
    logic [LEN_W-1:0]  in_len;
    logic [LDIX_W-1:0] in_ldix;
    logic [WORD_W-1:0] in_value;

    assign in_cmd   = s_axis_tdata[1:0];
    assign in_va    = s_axis_tdata[49:2];
    assign in_len   = s_axis_tdata[73:50];
    assign in_ldix  = s_axis_tdata[85:74];
    assign in_value = s_axis_tdata[149:86];

    // Control and walk registers
    state_t            state_reg,      state_next;
    logic [CMD_W-1:0]  cmd_reg,        cmd_next;
    logic [PAGE_W-1:0] page_reg,       page_next;
    logic [PAGE_W-1:0] end_reg,        end_next;
    logic [LVL_W-1:0]  level_reg,      level_next;
    logic [ADDR_W-1:0] slot_reg,       slot_next;
    logic              res_status_reg, res_status_next;
    logic [PA_W-1:0]   res_phys_reg,   res_phys_next;
    logic              out_valid_reg,  out_valid_next;
    logic              out_status_reg, out_status_next;
    logic [PA_W-1:0]   out_phys_reg,   out_phys_next;
    logic [PA_W-1:0]   window_base_reg;
    logic [PA_W-1:0]   root_reg;

    // Table memory and its ports
    logic [WORD_W-1:0] mem [MEM_WORDS];
    logic [WORD_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    // Slot address generation, shared by the root read and every descent
    logic [PA_W-1:0]   tbl_sel;
    logic [PA_W-1:0]   tbl_mask;
    logic [VIDX_W-1:0] idx_sel;
    logic [LVL_W-1:0]  lvl_sel;
    logic [SUM_W-1:0]  byte_sum;
    logic [ADDR_W-1:0] slot_calc;

    // Entry decode
    logic [WORD_W-1:0] entry;
    logic              entry_present;
    logic              entry_leaf;
    logic [PA_W-1:0]   page_offset;
    logic [PA_W-1:0]   phys_calc;
    logic [PAGE_W-1:0] end_sum;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_phys_reg, out_status_reg};

    // Build the word slot of the next table read
    always_comb
    begin
        tbl_sel   = (state_reg == S_CHECK) ? rd_data_reg[PA_W-1:0] : root_reg;
        lvl_sel   = (state_reg == S_CHECK) ? level_reg + 2'd1 : LVL_PML4;
        idx_sel   = va_index(page_reg[VA_W-1:0], lvl_sel);
        tbl_mask  = {tbl_sel[PA_W-1:12], 12'h000};
        byte_sum  = window_base_reg[SUM_W-1:0] + tbl_mask[SUM_W-1:0]
                    + SUM_W'({idx_sel, 3'b000});
        slot_calc = byte_sum[SUM_W-1:3];
    end

    // Decode the entry just read
    always_comb
    begin
        entry         = rd_data_reg;
        entry_present = entry[BIT_PRESENT];
        entry_leaf    = (level_reg == LVL_PT)
                        || (((level_reg == LVL_PDPT) || (level_reg == LVL_PD))
                            && entry[BIT_LARGE]);
        case (level_reg)
            LVL_PDPT: page_offset = {22'd0, page_reg[29:0]};
            LVL_PD:   page_offset = {31'd0, page_reg[20:0]};
            default:  page_offset = {40'd0, page_reg[11:0]};
        endcase
        phys_calc = {entry[PA_W-1:12], 12'h000} | page_offset;
        end_sum   = {2'b00, in_va} + PAGE_W'(in_len) + PAGE_ROUND;
    end

    // Sequence commands and drive the memory ports
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        page_next       = page_reg;
        end_next        = end_reg;
        level_next      = level_reg;
        slot_next       = slot_reg;
        res_status_next = res_status_reg;
        res_phys_next   = res_phys_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_phys_next   = out_phys_reg;
        mem_we          = 1'b0;
        mem_waddr       = slot_reg;
        mem_wdata       = rd_data_reg & NOEXEC_CLEAR_MASK;
        mem_re          = 1'b0;
        mem_raddr       = slot_calc;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd_next        = in_cmd;
                    res_status_next = 1'b0;
                    res_phys_next   = '0;
                    end_next        = {end_sum[PAGE_W-1:12], 12'h000};
                    if (in_cmd == CMD_MARK_EXEC)
                        page_next = {2'b00, in_va[VA_W-1:12], 12'h000};
                    else
                        page_next = {2'b00, in_va};
                    case (in_cmd)
                        CMD_LOAD:
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = ADDR_W'(in_ldix);
                            mem_wdata  = in_value;
                            state_next = S_DONE;
                        end
                        CMD_TRANSLATE, CMD_MARK_EXEC:
                            state_next = S_START;
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end

            // Issue the top-level read, or finish an exhausted range
            S_START:
            begin
                if ((cmd_reg == CMD_MARK_EXEC) && !(page_reg < end_reg))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    slot_next  = slot_calc;
                    level_next = LVL_PML4;
                    state_next = S_CHECK;
                end
            end

            // Check the entry; fault, finish at a leaf, or descend a level
            S_CHECK:
            begin
                if (!entry_present)
                begin
                    res_status_next = 1'b1;
                    res_phys_next   = '0;
                    state_next      = S_DONE;
                end
                else if (entry_leaf)
                begin
                    if (cmd_reg == CMD_TRANSLATE)
                    begin
                        res_phys_next = phys_calc;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        state_next = S_WRITE;
                    end
                end
                else
                begin
                    mem_re     = 1'b1;
                    slot_next  = slot_calc;
                    level_next = level_reg + 2'd1;
                end
            end

            // Write back the leaf with no-execute cleared and advance a step;
            // no read shares this cycle, so the next walk sees the new word
            S_WRITE:
            begin
                mem_we     = 1'b1;
                page_next  = page_reg + PAGE_STEP;
                state_next = S_START;
            end

            // Hand the result to the output register once it is free
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_phys_next   = res_phys_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // Hold state, walk context, configuration and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cmd_reg         <= CMD_LOAD;
            page_reg        <= '0;
            end_reg         <= '0;
            level_reg       <= LVL_PML4;
            slot_reg        <= '0;
            res_status_reg  <= 1'b0;
            res_phys_reg    <= '0;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= 1'b0;
            out_phys_reg    <= '0;
            window_base_reg <= '0;
            root_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            page_reg       <= page_next;
            end_reg        <= end_next;
            level_reg      <= level_next;
            slot_reg       <= slot_next;
            res_status_reg <= res_status_next;
            res_phys_reg   <= res_phys_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_phys_reg   <= out_phys_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_WINDOW_BASE: window_base_reg <= cfg_wdata;
                    CFG_ROOT_TABLE:  root_reg        <= cfg_wdata;
                endcase
            end
        end
    end

    // Table memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

endmodule

// File: bench/flpw_checker.sv
`timescale 1ns / 1ps
// Result checker for four_level_page_walker_unit: watches the register port and both streams,
// predicts each result from its own copy of the table memory, and counts mismatches.
// Depends on flpw_pkg for field widths, command codes, register indexes and entry bits.
module flpw_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [flpw_pkg::CFG_IX_W-1:0]    cfg_index,
    input  logic [flpw_pkg::PA_W-1:0]        cfg_wdata,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [flpw_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [flpw_pkg::OUT_DATA_W-1:0]  m_tdata,
    output int                               fail_count,
    output int                               results_owed
);

    import flpw_pkg::*;

    typedef struct packed {
        logic            status;
        logic [PA_W-1:0] phys;
    } walk_result_t;

    localparam int          DEPTH      = MEM_WORDS_DEF;
    localparam int          TOP_SHIFT  = 39;
    localparam int          MAX_SHOWN  = 60;
    localparam logic [63:0] FRAME_MASK = 64'h000F_FFFF_FFFF_F000;
    localparam logic [63:0] INDEX_MASK = 64'h1FF;
    localparam logic [63:0] OFFSET_4K  = 64'hFFF;
    localparam logic [63:0] STEP_16K   = 64'h4000;
    localparam logic [63:0] SPAN_1G    = 64'd1 << 30;
    localparam logic [63:0] SPAN_2M    = 64'd1 << 21;

    logic [WORD_W-1:0] table_copy [DEPTH];
    logic [PA_W-1:0]   window_q;
    logic [PA_W-1:0]   root_q;
    walk_result_t      owed_results [$];
    int                shown;

    // Walk the four levels for va; on success return the address and the leaf word slot
    function automatic bit walk_tables(input logic [63:0] va, output logic [PA_W-1:0] phys,
                                       output int leaf);
        logic [63:0] tbl;
        logic [63:0] entry;
        logic [63:0] byte_addr;
        logic [63:0] span;
        int          slot;
        tbl  = 64'(root_q);
        phys = '0;
        leaf = 0;
        for (int lvl = 0; lvl < 4; lvl++)
        begin
            byte_addr = 64'(window_q) + (tbl & FRAME_MASK)
                      + (((va >> (TOP_SHIFT - 9 * lvl)) & INDEX_MASK) << 3);
            slot  = int'((byte_addr >> 3) & 64'(DEPTH - 1));
            entry = table_copy[slot];
            if (!entry[BIT_PRESENT])
                return 1'b0;
            // a large page ends the walk only at the middle two levels
            if (lvl == int'(LVL_PT) ||
                (entry[BIT_LARGE] && (lvl == int'(LVL_PDPT) || lvl == int'(LVL_PD))))
            begin
                span = (lvl == int'(LVL_PDPT)) ? SPAN_1G :
                       (lvl == int'(LVL_PD))   ? SPAN_2M : (OFFSET_4K + 64'd1);
                phys = PA_W'((entry & FRAME_MASK) | (va & (span - 64'd1)));
                leaf = slot;
                return 1'b1;
            end
            tbl = entry;
        end
        return 1'b0;
    endfunction

    // Apply one command beat to the table copy and return the result it owes
    function automatic walk_result_t apply_command(input logic [IN_DATA_W-1:0] beat);
        logic [CMD_W-1:0]  cmd;
        logic [VA_W-1:0]   va;
        logic [LEN_W-1:0]  len;
        logic [LDIX_W-1:0] idx;
        logic [WORD_W-1:0] val;
        logic [63:0]       pg;
        logic [63:0]       stop;
        logic [PA_W-1:0]   phys;
        int                leaf;
        walk_result_t      res;
        {val, idx, len, va, cmd} = beat[149:0];
        res = '0;
        case (cmd)
            CMD_LOAD:
                table_copy[idx] = val;
            CMD_TRANSLATE:
            begin
                if (walk_tables(64'(va), phys, leaf))
                    res.phys = phys;
                else
                    res.status = 1'b1;
            end
            CMD_MARK_EXEC:
            begin
                pg   = 64'(va) & ~OFFSET_4K;
                stop = (64'(va) + 64'(len) + OFFSET_4K) & ~OFFSET_4K;
                // clear no-execute page by page, stop at the first fault
                while (pg < stop)
                begin
                    if (!walk_tables(pg, phys, leaf))
                    begin
                        res.status = 1'b1;
                        break;
                    end
                    table_copy[leaf] = table_copy[leaf] & NOEXEC_CLEAR_MASK;
                    pg = pg + STEP_16K;
                end
            end
            default:
                res = '0;
        endcase
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (shown < MAX_SHOWN)
            $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
        shown++;
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        walk_result_t got;
        walk_result_t want;
        if (!rst_n)
        begin
            window_q = '0;
            root_q   = '0;
            owed_results.delete();
            results_owed = 0;
            fail_count   = 0;
            shown        = 0;
        end
        else
        begin
            // compare a result beat with the oldest prediction
            if (m_tvalid && m_tready)
            begin
                got.status = m_tdata[0];
                got.phys   = m_tdata[PA_W:1];
                if (owed_results.size() == 0)
                    flag_mismatch("unexpected result beat", 64'(got), 64'd0);
                else
                begin
                    want = owed_results.pop_front();
                    if (got.status !== want.status)
                        flag_mismatch("status", 64'(got.status), 64'(want.status));
                    if (got.phys !== want.phys)
                        flag_mismatch("phys_addr", 64'(got.phys), 64'(want.phys));
                end
            end
            // track register writes
            if (cfg_we)
            begin
                if (cfg_index == CFG_WINDOW_BASE)
                    window_q = cfg_wdata;
                else if (cfg_index == CFG_ROOT_TABLE)
                    root_q = cfg_wdata;
            end
            // predict every accepted command beat
            if (s_tvalid && s_tready)
                owed_results.push_back(apply_command(s_tdata));
            results_owed = owed_results.size();
        end
    end

endmodule

// File: bench/tb_four_level_page_walker_unit.sv
`timescale 1ns / 1ps
// Testbench top for four_level_page_walker_unit: builds page table trees through load
// commands, walks them with translate and mark-executable, paces both streams and reports.
// Depends on flpw_pkg, four_level_page_walker_unit and flpw_checker.
module tb_four_level_page_walker_unit;
    import flpw_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
    localparam int          DEPTH        = MEM_WORDS_DEF;
    localparam int          TOP_SHIFT    = 39;
    localparam int          PHASE_ITEMS  = 255;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          MARK_LOADS   = 24;
    localparam int          WALK_LOADS   = 8;
    localparam logic [63:0] FRAME_MASK   = 64'h000F_FFFF_FFFF_F000;
    localparam logic [63:0] INDEX_MASK   = 64'h1FF;
    localparam logic [63:0] OFFSET_4K    = 64'hFFF;
    localparam logic [63:0] STEP_16K     = 64'h4000;
    localparam logic [PA_W-1:0] PA_MAX   = '1;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IX_W-1:0]   cfg_index;
    logic [PA_W-1:0]       cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    int                    fail_count;
    int                    results_owed;

    // stimulus-side view of which table words hold loaded values
    bit                    word_loaded [DEPTH];
    logic [WORD_W-1:0]     word_value  [DEPTH];
    logic [PA_W-1:0]       window_set;
    logic [PA_W-1:0]       root_set;
    logic [VA_W-1:0]       last_va;
    int                    burst_left;
    int                    items_sent;
    bit                    hold_req;

    four_level_page_walker_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    flpw_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_axis_tvalid),
        .s_tready     (s_axis_tready),
        .s_tdata      (s_axis_tdata),
        .m_tvalid     (m_axis_tvalid),
        .m_tready     (m_axis_tready),
        .m_tdata      (m_axis_tdata),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard stop
    initial
    begin
        #40_000_000;
        $display("FAIL four_level_page_walker_unit");
        $finish;
    end

    // result side: stall patterns that change every segment, plus one long hold-off
    initial
    begin : sink_pacing
        int mode;
        int seg;
        m_axis_tready = 1'b0;
        seg = 0;
        mode = 0;
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (seg == 0)
                begin
                    mode = $urandom_range(0, 2);
                    seg  = $urandom_range(20, 200);
                end
                seg--;
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 1) == 0);
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
                @(negedge clk);
            end
        end
    end

    function automatic logic [VA_W-1:0] rand_va();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[VA_W-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // mostly fresh addresses, sometimes a neighbor of the last one to share tables
    function automatic logic [VA_W-1:0] pick_va();
        if ($urandom_range(0, 3) == 0)
            return last_va ^ VA_W'($urandom_range(0, 32'h3F_FFFF));
        return rand_va();
    endfunction

    function automatic logic [LEN_W-1:0] pick_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 10)
            return '0;
        if (p < 80)
            return LEN_W'($urandom_range(0, 32'hFFFF));
        if (p < 95)
            return LEN_W'($urandom_range(0, 32'h3FFFF));
        return LEN_W'($urandom);
    endfunction

    // random table word; a present bit only while the load budget lasts
    function automatic logic [WORD_W-1:0] make_entry(input int lvl, input bit live);
        logic [WORD_W-1:0] e;
        e = rand_word();
        e[BIT_PRESENT] = live && ($urandom_range(0, 15) != 0);
        if (lvl == int'(LVL_PDPT))
            e[BIT_LARGE] = ($urandom_range(0, 3) == 0);
        else if (lvl == int'(LVL_PD))
            e[BIT_LARGE] = ($urandom_range(0, 2) == 0);
        return e;
    endfunction

    // First never-loaded word on the walk of va, or -1 when the walk ends on loaded words
    function automatic int first_unloaded(input logic [63:0] va, output int gap_level,
                                          output bit reaches_leaf);
        logic [63:0] tbl;
        logic [63:0] entry;
        logic [63:0] byte_addr;
        int          slot;
        tbl = 64'(root_set);
        gap_level = 0;
        reaches_leaf = 1'b0;
        for (int lvl = 0; lvl < 4; lvl++)
        begin
            byte_addr = 64'(window_set) + (tbl & FRAME_MASK)
                      + (((va >> (TOP_SHIFT - 9 * lvl)) & INDEX_MASK) << 3);
            slot = int'((byte_addr >> 3) & 64'(DEPTH - 1));
            if (!word_loaded[slot])
            begin
                gap_level = lvl;
                return slot;
            end
            entry = word_value[slot];
            if (!entry[BIT_PRESENT])
                return -1;
            if (lvl == int'(LVL_PT) ||
                (entry[BIT_LARGE] && (lvl == int'(LVL_PDPT) || lvl == int'(LVL_PD))))
            begin
                reaches_leaf = 1'b1;
                return -1;
            end
            tbl = entry;
        end
        return -1;
    endfunction

    // Offer one command beat in the current burst and wait for it to be taken
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [VA_W-1:0] va,
                             input logic [LEN_W-1:0] len, input logic [LDIX_W-1:0] idx,
                             input logic [WORD_W-1:0] val);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, val, idx, len, va, cmd};
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
        burst_left--;
        items_sent++;
        if (cmd == CMD_LOAD)
        begin
            word_loaded[idx] = 1'b1;
            word_value[idx]  = val;
        end
    endtask

    // Load every missing word on the walk of va; out of budget, load not-present words
    task automatic cover_path(input logic [63:0] va, inout int budget, output bit reaches_leaf);
        int slot;
        int lvl;
        slot = first_unloaded(va, lvl, reaches_leaf);
        while (slot >= 0)
        begin
            send_item(CMD_LOAD, rand_va(), LEN_W'($urandom), LDIX_W'(slot),
                      make_entry(lvl, budget > 0));
            budget--;
            slot = first_unloaded(va, lvl, reaches_leaf);
        end
    endtask

    // Drop valid, wait out every owed result and let the walker settle
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(negedge clk); while (results_owed != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Write both registers; call only while the block is idle
    task automatic set_tables(input logic [PA_W-1:0] wbase, input logic [PA_W-1:0] root);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_WINDOW_BASE;
        cfg_wdata <= wbase;
        @(negedge clk);
        cfg_index <= CFG_ROOT_TABLE;
        cfg_wdata <= root;
        @(negedge clk);
        cfg_we <= 1'b0;
        window_set = wbase;
        root_set   = root;
    endtask

    // Random traffic, mostly walks over trees that are built on the fly
    task automatic run_traffic(input int quota);
        int               stop_at;
        int               pick;
        int               budget;
        int               slot;
        int               lvl;
        bit               ok;
        logic [VA_W-1:0]  va;
        logic [LEN_W-1:0] len;
        logic [63:0]      pg;
        logic [63:0]      stop;
        stop_at = items_sent + quota;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            va   = pick_va();
            if (pick < 50)
            begin
                budget = WALK_LOADS;
                cover_path(64'(va), budget, ok);
                send_item(CMD_TRANSLATE, va, LEN_W'($urandom), LDIX_W'($urandom), rand_word());
                last_va = va;
            end
            else if (pick < 78)
            begin
                len    = pick_len();
                budget = MARK_LOADS;
                pg     = 64'(va) & ~OFFSET_4K;
                stop   = (64'(va) + 64'(len) + OFFSET_4K) & ~OFFSET_4K;
                while (pg < stop)
                begin
                    cover_path(pg, budget, ok);
                    if (!ok)
                        break;
                    pg = pg + STEP_16K;
                end
                send_item(CMD_MARK_EXEC, va, len, LDIX_W'($urandom), rand_word());
                last_va = va;
            end
            else if (pick < 92)
            begin
                // stray load anywhere, possibly over a live table word
                send_item(CMD_LOAD, rand_va(), LEN_W'($urandom), LDIX_W'($urandom), rand_word());
            end
            else if (pick < 96)
            begin
                send_item(CMD_UNKNOWN, va, LEN_W'($urandom), LDIX_W'($urandom), rand_word());
            end
            else
            begin
                // bare translate, only where the walk stays on loaded words
                slot = first_unloaded(64'(va), lvl, ok);
                if (slot < 0)
                    send_item(CMD_TRANSLATE, va, LEN_W'($urandom), LDIX_W'($urandom),
                              rand_word());
            end
        end
    endtask

    // Hand-built tree at table addresses 0, 0x1000, 0x2000 and 0x3000
    task automatic run_directed();
        send_item(CMD_LOAD, '0, '0, 12'd0,    64'h8000_0000_0000_1081);
        send_item(CMD_LOAD, '0, '0, 12'd512,  64'h0000_0000_0000_2003);
        send_item(CMD_LOAD, '0, '0, 12'd513,  64'h800F_FFFF_C000_0081);
        send_item(CMD_LOAD, '0, '0, 12'd1024, 64'h0000_0000_0000_3001);
        send_item(CMD_LOAD, '0, '0, 12'd1025, 64'h0000_0012_3460_0081);
        send_item(CMD_LOAD, '0, '0, 12'd1026, 64'h7FFF_FFFF_FFFF_FFFE);
        send_item(CMD_LOAD, '0, '0, 12'd1536, 64'hFFFF_FFFF_FFFF_F0FF);
        send_item(CMD_LOAD, '0, '0, 12'd1540, 64'h8000_0000_0555_5003);
        send_item(CMD_LOAD, '0, '0, 12'd1544, 64'h0);
        send_item(CMD_LOAD, '0, '0, 12'd511,  64'hFFFF_FFFF_FFFF_FFFE);
        send_item(CMD_LOAD, '1, '1, 12'd4095, 64'hFFFF_FFFF_FFFF_FFFF);
        // 4 KB leaf, 1 GB page, 2 MB page, fault in the middle, fault at the top
        send_item(CMD_TRANSLATE, 48'h0000_0000_0ABC, '0, '0, '0);
        send_item(CMD_TRANSLATE, 48'h0000_7FFF_FFFF, '0, '0, '0);
        send_item(CMD_TRANSLATE, 48'h0000_003F_FFFF, '0, '0, '0);
        send_item(CMD_TRANSLATE, 48'h0000_0040_0000, '0, '0, '0);
        send_item(CMD_TRANSLATE, 48'hFFFF_FFFF_FFFF, '0, '0, '0);
        // empty range, two pages, unaligned start, fault, long runs over large pages
        send_item(CMD_MARK_EXEC, 48'h0, 24'h0, '0, '0);
        send_item(CMD_MARK_EXEC, 48'h0, 24'h8000, '0, '0);
        send_item(CMD_MARK_EXEC, 48'h123, 24'h3F00, '0, '0);
        send_item(CMD_MARK_EXEC, 48'h8000, 24'h4000, '0, '0);
        send_item(CMD_MARK_EXEC, 48'h0000_0020_0000, 24'hFF_FFFF, '0, '0);
        send_item(CMD_MARK_EXEC, 48'h0000_4000_0000, 24'hFF_FFFF, '0, '0);
        send_item(CMD_UNKNOWN, '1, '1, '1, '1);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        window_set    = '0;
        root_set      = '0;
        last_va       = '0;
        burst_left    = 0;
        items_sent    = 0;
        hold_req      = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        set_tables('0, '0);
        run_directed();
        run_traffic(PHASE_ITEMS);
        drain_results();

        // both registers at their top value, so every address wraps
        set_tables(PA_MAX, PA_MAX);
        run_traffic(PHASE_ITEMS);
        drain_results();

        // long result stall while commands keep coming
        set_tables(PA_W'({$urandom, $urandom}), PA_W'({$urandom, $urandom}));
        hold_req = 1'b1;
        run_traffic(PHASE_ITEMS);
        drain_results();

        // byte-offset window; sender pauses for every result halfway through
        set_tables(PA_W'($urandom_range(1, 7)), PA_W'({$urandom, $urandom}));
        run_traffic(PHASE_ITEMS / 2);
        drain_results();
        run_traffic(PHASE_ITEMS - PHASE_ITEMS / 2);
        drain_results();

        set_tables(PA_W'({$urandom, $urandom}), PA_W'({$urandom, $urandom}));
        run_traffic(PHASE_ITEMS);
        drain_results();

        set_tables('0, PA_W'({$urandom, $urandom}));
        run_traffic(PHASE_ITEMS);
        drain_results();

        if (fail_count == 0)
            $display("PASS four_level_page_walker_unit");
        else
            $display("FAIL four_level_page_walker_unit");
        $finish;
    end

endmodule

// File: sim.f
design/flpw_pkg.sv
design/four_level_page_walker_unit.sv
bench/flpw_checker.sv
bench/tb_four_level_page_walker_unit.sv
